// ----- src/mowt_pkg.sv -----
// Shared types, command codes and constants of the mecanum odometry waypoint tracker.
// Used by mowt_ctrl, mowt_dp and the top level; depends on nothing else.
`default_nettype none
package mowt_pkg;

  // Datapath operation codes issued by the controller.
  localparam logic [4:0] OP_NONE    = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_MUL_X   = 5'd2;
  localparam logic [4:0] OP_MUL_Y   = 5'd3;
  localparam logic [4:0] OP_BODY    = 5'd4;
  localparam logic [4:0] OP_DIV     = 5'd5;
  localparam logic [4:0] OP_HEAD    = 5'd6;
  localparam logic [4:0] OP_ANGLE   = 5'd7;
  localparam logic [4:0] OP_MUL_DY  = 5'd8;
  localparam logic [4:0] OP_SCALE_Y = 5'd9;
  localparam logic [4:0] OP_CORDIC  = 5'd10;
  localparam logic [4:0] OP_ACCUM   = 5'd11;
  localparam logic [4:0] OP_GOAL    = 5'd12;
  localparam logic [4:0] OP_SQ_X    = 5'd13;
  localparam logic [4:0] OP_SQ_Y    = 5'd14;
  localparam logic [4:0] OP_SQ_R    = 5'd15;
  localparam logic [4:0] OP_OUT     = 5'd16;

  // Configuration register indexes.
  localparam logic [2:0] REG_WP0_X  = 3'd0;
  localparam logic [2:0] REG_WP0_Y  = 3'd1;
  localparam logic [2:0] REG_WP1_X  = 3'd2;
  localparam logic [2:0] REG_WP1_Y  = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;

  // Last step indexes of the iterative units. A division is a reciprocal multiply
  // followed by one correction step.
  localparam logic [5:0] DIV_LAST    = 6'd1;
  localparam logic [5:0] CORDIC_LAST = 6'd15;

  // Reciprocals: floor(2^38 / 260) and floor(2^42 / 5760).
  localparam logic [29:0] RECIP_HEAD      = 30'd1057222719;
  localparam logic [29:0] RECIP_FULL_TURN = 30'd763549741;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [4:0] op;
    logic [3:0] iter;
    logic       div_full_turn;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // CORDIC arctangent table, 1/65536 degree.
  function automatic logic [21:0] atan_of(input logic [3:0] i);
    logic [21:0] v;
    unique case (i)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234379;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29335;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- src/mowt_ctrl.sv -----
// Sequencing state machine of the mecanum odometry waypoint tracker.
// Depends on mowt_pkg for the command and status types.
`default_nettype none
module mowt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mowt_pkg::status_t status,
  output mowt_pkg::cmd_t        cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_MULX   = 5'd1;
  localparam logic [4:0] ST_MULY   = 5'd2;
  localparam logic [4:0] ST_BODY   = 5'd3;
  localparam logic [4:0] ST_DIVW   = 5'd4;
  localparam logic [4:0] ST_HEAD   = 5'd5;
  localparam logic [4:0] ST_DIVM   = 5'd6;
  localparam logic [4:0] ST_ANGLE  = 5'd7;
  localparam logic [4:0] ST_MULDY  = 5'd8;
  localparam logic [4:0] ST_SCALEY = 5'd9;
  localparam logic [4:0] ST_CORD   = 5'd10;
  localparam logic [4:0] ST_ACCUM  = 5'd11;
  localparam logic [4:0] ST_GOAL   = 5'd12;
  localparam logic [4:0] ST_SQX    = 5'd13;
  localparam logic [4:0] ST_SQY    = 5'd14;
  localparam logic [4:0] ST_SQR    = 5'd15;
  localparam logic [4:0] ST_OUT    = 5'd16;

  logic [4:0] state, state_next;
  logic [5:0] cnt, cnt_next;

  assign in_ready = (state == ST_IDLE);

  // Next state, step counter and command decode.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd.op = mowt_pkg::OP_NONE;
    cmd.iter = cnt[3:0];
    cmd.div_full_turn = (state == ST_DIVM);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = mowt_pkg::OP_LOAD;
          state_next = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd.op = mowt_pkg::OP_MUL_X;
        state_next = ST_MULY;
      end
      ST_MULY: begin
        cmd.op = mowt_pkg::OP_MUL_Y;
        state_next = ST_BODY;
      end
      ST_BODY: begin
        cmd.op = mowt_pkg::OP_BODY;
        cnt_next = '0;
        state_next = ST_DIVW;
      end
      ST_DIVW, ST_DIVM: begin
        cmd.op = mowt_pkg::OP_DIV;
        cnt_next = cnt + 6'd1;
        if (cnt == mowt_pkg::DIV_LAST) begin
          cnt_next = '0;
          state_next = (state == ST_DIVW) ? ST_HEAD : ST_ANGLE;
        end
      end
      ST_HEAD: begin
        cmd.op = mowt_pkg::OP_HEAD;
        cnt_next = '0;
        state_next = ST_DIVM;
      end
      ST_ANGLE: begin
        cmd.op = mowt_pkg::OP_ANGLE;
        state_next = ST_MULDY;
      end
      ST_MULDY: begin
        cmd.op = mowt_pkg::OP_MUL_DY;
        state_next = ST_SCALEY;
      end
      ST_SCALEY: begin
        cmd.op = mowt_pkg::OP_SCALE_Y;
        cnt_next = '0;
        state_next = ST_CORD;
      end
      ST_CORD: begin
        cmd.op = mowt_pkg::OP_CORDIC;
        cnt_next = cnt + 6'd1;
        if (cnt == mowt_pkg::CORDIC_LAST) begin
          cnt_next = '0;
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.op = mowt_pkg::OP_ACCUM;
        state_next = ST_GOAL;
      end
      ST_GOAL: begin
        cmd.op = mowt_pkg::OP_GOAL;
        state_next = ST_SQX;
      end
      ST_SQX: begin
        cmd.op = mowt_pkg::OP_SQ_X;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.op = mowt_pkg::OP_SQ_Y;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.op = mowt_pkg::OP_SQ_R;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op = mowt_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/mowt_dp.sv -----
// Datapath of the mecanum odometry waypoint tracker: shared multiplier, divider,
// CORDIC, position integrators, reach test, configuration and output registers.
// Depends on mowt_pkg for the command codes and the arctangent table.
`default_nettype none
module mowt_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mowt_pkg::cmd_t   cmd,
  output mowt_pkg::status_t     status,
  input  wire logic [127:0]     in_data,
  input  wire logic             cfg_valid,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [95:0]           out_data
);

  // Configuration registers.
  logic signed [15:0] wp0_x, wp0_y, wp1_x, wp1_y;
  logic [15:0]        reach_radius;

  // Working registers.
  logic signed [33:0] sx, sy, sw;
  logic signed [65:0] p;
  logic signed [39:0] bx, prev_x, prev_y, dx, dy;
  logic [37:0]        dvd;
  logic [13:0]        rem;
  logic [61:0]        rp;
  logic signed [31:0] w;
  logic signed [13:0] hd;
  logic               neg;
  logic signed [49:0] x, y;
  logic signed [25:0] z;
  logic signed [39:0] pos_x, pos_y;
  logic signed [40:0] gx, gy;
  logic               box;
  logic [49:0]        acc;
  logic               idx;

  // Output register.
  logic signed [39:0] o_x, o_y;
  logic signed [13:0] o_hd;
  logic               o_idx, o_hit;

  logic signed [31:0] lf, lr, rf, rr;
  logic signed [40:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [65:0] prod, p_rnd16;
  logic signed [39:0] body_new;
  logic [33:0]        sw_mag;
  logic [37:0]        head_dvd;
  logic [31:0]        rm_a;
  logic [29:0]        rm_b;
  logic [61:0]        rm_prod;
  logic [29:0]        hq0, hq;
  logic [10:0]        hr;
  logic [6:0]         tq0;
  logic [13:0]        tr, trem;
  logic signed [13:0] at, a1, a2, a3;
  logic               neg_next;
  logic signed [49:0] xs, ys, x_sc, xr, yr;
  logic [21:0]        atan;
  logic signed [15:0] wpx, wpy;
  logic [40:0]        gxa, gya;
  logic [23:0]        rad;
  logic               hit;

  assign lf = in_data[31:0];
  assign lr = in_data[63:32];
  assign rf = in_data[95:64];
  assign rr = in_data[127:96];

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = 41'(sx);
    mul_b = 25'sd491826;
    unique case (cmd.op)
      mowt_pkg::OP_MUL_Y: begin
        mul_a = 41'(sy);
      end
      mowt_pkg::OP_ANGLE: begin
        mul_a = 41'(dx);
        mul_b = 25'sd39797;
      end
      mowt_pkg::OP_MUL_DY: begin
        mul_a = 41'(dy);
        mul_b = 25'sd39797;
      end
      mowt_pkg::OP_SQ_X: begin
        mul_a = $signed({17'b0, gxa[23:0]});
        mul_b = $signed({1'b0, gxa[23:0]});
      end
      mowt_pkg::OP_SQ_Y: begin
        mul_a = $signed({17'b0, gya[23:0]});
        mul_b = $signed({1'b0, gya[23:0]});
      end
      mowt_pkg::OP_SQ_R: begin
        mul_a = $signed({17'b0, rad});
        mul_b = $signed({1'b0, rad});
      end
      default: begin
        mul_a = 41'(sx);
      end
    endcase
  end

  assign prod = 66'(mul_a) * 66'(mul_b);

  // Body position rounding and heading dividend.
  assign p_rnd16  = p + 66'sd32768;
  assign body_new = p_rnd16[55:16];
  assign sw_mag   = sw[33] ? 34'(-sw) : 34'(sw);
  assign head_dvd = {sw_mag, 4'b0} + {3'b0, sw_mag, 1'b0} + {4'b0, sw_mag} + 38'd130;

  // Division by a constant: the reciprocal product gives a quotient estimate
  // that is low by at most two (by 260) or one (by a full turn).
  assign rm_a    = cmd.div_full_turn ? {2'b0, dvd[29:0]} : dvd[37:6];
  assign rm_b    = cmd.div_full_turn ? mowt_pkg::RECIP_FULL_TURN : mowt_pkg::RECIP_HEAD;
  assign rm_prod = 62'(rm_a) * 62'(rm_b);

  // Heading quotient: the remainder is below 780, so eleven bits hold it.
  assign hq0 = rp[61:32];
  assign hr  = dvd[10:0] - {hq0[2:0], 8'b0} - {hq0[8:0], 2'b0};
  assign hq  = hq0 + {29'b0, (hr >= 11'd260)} + {29'b0, (hr >= 11'd520)};

  // Remainder by a full turn: below 11520 before the last correction.
  assign tq0  = rp[48:42];
  assign tr   = dvd[13:0] - {tq0[1:0], 12'b0} - {tq0[3:0], 10'b0}
                - {tq0[4:0], 9'b0} - {tq0[6:0], 7'b0};
  assign trem = (tr >= 14'd5760) ? tr - 14'd5760 : tr;

  // Angle reduction to the range of the rotator.
  always_comb begin
    at = w[31] ? -$signed({1'b0, rem[12:0]}) : $signed({1'b0, rem[12:0]});
    a1 = at[13] ? at + 14'sd5760 : at;
    a2 = (a1 >= 14'sd2880) ? a1 - 14'sd5760 : a1;
    neg_next = 1'b0;
    a3 = a2;
    if (a2 > 14'sd1440) begin
      neg_next = 1'b1;
      a3 = a2 - 14'sd2880;
    end else if (a2 < -14'sd1440) begin
      neg_next = 1'b1;
      a3 = a2 + 14'sd2880;
    end
  end

  // CORDIC step terms and final rounding.
  assign x_sc = p[57:8];
  assign xs   = x >>> cmd.iter;
  assign ys   = y >>> cmd.iter;
  assign atan = mowt_pkg::atan_of(cmd.iter);
  assign xr   = x + 50'sd128;
  assign yr   = y + 50'sd128;

  // Reach test terms.
  assign wpx = idx ? wp1_x : wp0_x;
  assign wpy = idx ? wp1_y : wp0_y;
  assign gxa = gx[40] ? 41'(-gx) : 41'(gx);
  assign gya = gy[40] ? 41'(-gy) : 41'(gy);
  assign rad = {reach_radius, 8'h00};
  assign hit = box && (acc < p[49:0]);

  assign status.out_free = !out_valid || out_ready;

  // Working registers, one operation per command.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mowt_pkg::OP_LOAD: begin
        sx <= 34'(rf) + 34'(lf) - 34'(lr) - 34'(rr);
        sy <= 34'(lf) + 34'(lr) - 34'(rf) - 34'(rr);
        sw <= 34'(lf) + 34'(lr) + 34'(rf) + 34'(rr);
      end
      mowt_pkg::OP_MUL_X: begin
        p <= prod;
      end
      mowt_pkg::OP_MUL_Y: begin
        bx <= body_new;
        p <= prod;
      end
      mowt_pkg::OP_BODY: begin
        dx <= bx - prev_x;
        dy <= body_new - prev_y;
        dvd <= head_dvd;
        rem <= '0;
      end
      mowt_pkg::OP_DIV: begin
        if (cmd.iter == 4'd0) begin
          rp <= rm_prod;
        end else if (cmd.div_full_turn) begin
          rem <= trem;
        end else begin
          dvd <= {8'b0, hq};
        end
      end
      mowt_pkg::OP_HEAD: begin
        w <= sw[33] ? -$signed({1'b0, dvd[30:0]}) : $signed({1'b0, dvd[30:0]});
        dvd <= {7'b0, dvd[30:0]};
        rem <= '0;
      end
      mowt_pkg::OP_ANGLE: begin
        hd <= (w > 32'sd5760 || w < -32'sd5760) ? at : w[13:0];
        neg <= neg_next;
        z <= {a3, 12'b0};
        p <= prod;
      end
      mowt_pkg::OP_MUL_DY: begin
        x <= neg ? -x_sc : x_sc;
        p <= prod;
      end
      mowt_pkg::OP_SCALE_Y: begin
        y <= neg ? -x_sc : x_sc;
      end
      mowt_pkg::OP_CORDIC: begin
        if (!z[25]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - $signed({4'b0, atan});
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + $signed({4'b0, atan});
        end
      end
      mowt_pkg::OP_GOAL: begin
        gx <= 41'($signed({wpx, 8'h00})) - 41'(pos_x);
        gy <= 41'($signed({wpy, 8'h00})) - 41'(pos_y);
      end
      mowt_pkg::OP_SQ_X: begin
        box <= (gxa < {17'b0, rad}) && (gya < {17'b0, rad});
        p <= prod;
      end
      mowt_pkg::OP_SQ_Y: begin
        acc <= p[49:0];
        p <= prod;
      end
      mowt_pkg::OP_SQ_R: begin
        acc <= acc + p[49:0];
        p <= prod;
      end
      default: begin
      end
    endcase
  end

  // Persistent odometry state.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      pos_x <= '0;
      pos_y <= '0;
      idx <= 1'b0;
    end else begin
      if (cmd.op == mowt_pkg::OP_BODY) begin
        prev_x <= bx;
        prev_y <= body_new;
      end
      if (cmd.op == mowt_pkg::OP_ACCUM) begin
        pos_x <= pos_x + xr[47:8];
        pos_y <= pos_y - yr[47:8];
      end
      if (cmd.op == mowt_pkg::OP_OUT) begin
        idx <= idx ^ hit;
      end
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp0_x <= 16'sd0;
      wp0_y <= -16'sd700;
      wp1_x <= 16'sd0;
      wp1_y <= 16'sd700;
      reach_radius <= 16'd80;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mowt_pkg::REG_WP0_X:  wp0_x <= cfg_data;
        mowt_pkg::REG_WP0_Y:  wp0_y <= cfg_data;
        mowt_pkg::REG_WP1_X:  wp1_x <= cfg_data;
        mowt_pkg::REG_WP1_Y:  wp1_y <= cfg_data;
        mowt_pkg::REG_RADIUS: reach_radius <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded when the result is final, held until transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == mowt_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mowt_pkg::OP_OUT) begin
      o_x <= pos_x;
      o_y <= pos_y;
      o_hd <= hd;
      o_idx <= idx ^ hit;
      o_hit <= hit;
    end
  end

  assign out_data = {o_hit, o_idx, o_hd, o_y, o_x};

endmodule
`default_nettype wire

// ----- src/mecanum_odometry_waypoint_tracker.sv -----
// Top level of the mecanum odometry waypoint tracker.
// Instantiates mowt_ctrl and mowt_dp; depends on mowt_pkg.
//
// Usage:
//   The slave stream takes one item per control tick: four accumulated wheel
//   angles. The block integrates a field position, wraps the heading and
//   toggles between two waypoints when the position comes inside the reach
//   radius. One result item leaves on the master stream for each input.
//   Configuration writes (waypoints and radius) are taken on the cfg channel
//   at any time, with cfg_ready always high; write them while the block idles.
// Timing:
//   Two constant divisions (heading scaling and wrap by a full turn) are each
//   done as a reciprocal multiply and a correction, and the 16-step CORDIC
//   rotation follows the shared multiplier steps. The next item is taken once
//   the result is in the output register, even while that result still waits
//   for the receiver.
// Reset and stall:
//   Reset clears position, history and waypoint index and restores the
//   register defaults. A stalled receiver holds the result; a finished item
//   then waits before the output register until it is free.
`default_nettype none
module mecanum_odometry_waypoint_tracker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // angle_left_front, angle_left_rear, angle_right_front, angle_right_rear
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // field_x[39:0], field_y[79:40], heading[93:80], target_index[94], reached[95]
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  mowt_pkg::cmd_t    cmd;
  mowt_pkg::status_t status;
  logic              in_ready;

  assign s_axis_tready = in_ready;
  assign cfg_ready = 1'b1;

  mowt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mowt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- sim/mecanum_odometry_waypoint_tracker_tb.sv -----
// Self-checking testbench of the mecanum odometry waypoint tracker.
// Depends on mowt_pkg and mecanum_odometry_waypoint_tracker.
// A class predicts each result from the accepted wheel angles and checks the output stream.
`timescale 1ns / 100ps

// Predicts odometry results and holds them until the block delivers them.
class odometry_scoreboard;
  typedef struct {
    logic [39:0] field_x;
    logic [39:0] field_y;
    logic [13:0] heading;
    logic        target_index;
    logic        reached;
  } odo_result_t;

  odo_result_t pending[$];
  longint wp_x[2];
  longint wp_y[2];
  longint radius;
  longint prev_bx, prev_by, pos_x, pos_y;
  bit     wp_sel;
  int     errors;
  longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function new();
    wp_x[0] = 0; wp_y[0] = -700; wp_x[1] = 0; wp_y[1] = 700;
    radius = 80;
    prev_bx = 0; prev_by = 0; pos_x = 0; pos_y = 0;
    wp_sel = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      mowt_pkg::REG_WP0_X:  wp_x[0] = longint'($signed(val));
      mowt_pkg::REG_WP0_Y:  wp_y[0] = longint'($signed(val));
      mowt_pkg::REG_WP1_X:  wp_x[1] = longint'($signed(val));
      mowt_pkg::REG_WP1_Y:  wp_y[1] = longint'($signed(val));
      mowt_pkg::REG_RADIUS: radius = longint'(val);
      default: ;
    endcase
  endfunction

  function longint wrap40(longint v);
    logic signed [39:0] t;
    t = v[39:0];
    return longint'(t);
  endfunction

  function longint body_of(longint s);
    return (s * 491826 + 32768) >>> 16;
  endfunction

  // Rotates the delta by the heading with a 16-step CORDIC in 1/65536 degree.
  function void rotate(longint x, longint y, longint w, output longint rx, output longint ry);
    longint a, z, xs, ys;
    a = w % 5760;
    if (a < 0) a += 5760;
    if (a >= 2880) a -= 5760;
    x = (x * 39797) >>> 8;
    y = (y * 39797) >>> 8;
    if (a > 1440) begin
      x = -x; y = -y; a -= 2880;
    end else if (a < -1440) begin
      x = -x; y = -y; a += 2880;
    end
    z = a * 4096;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= atan_deg[i];
      end else begin
        x = x + ys; y = y - xs; z += atan_deg[i];
      end
    end
    rx = (x + 128) >>> 8;
    ry = (y + 128) >>> 8;
  endfunction

  // Notes an accepted transfer of wheel angles and queues the predicted result.
  function void note_input(logic [127:0] d);
    longint lf, lr, rf, rr, bx, by, sw, mag, w, rx, ry, hd, gx, gy, rad;
    odo_result_t r;
    lf = longint'($signed(d[31:0]));
    lr = longint'($signed(d[63:32]));
    rf = longint'($signed(d[95:64]));
    rr = longint'($signed(d[127:96]));
    bx = body_of(rf + lf - lr - rr);
    by = body_of(lf + lr - rf - rr);
    sw = lf + lr + rf + rr;
    mag = ((sw < 0) ? -sw : sw) * 19;
    w = (mag + 130) / 260;
    if (sw < 0) w = -w;
    rotate(bx - prev_bx, by - prev_by, w, rx, ry);
    prev_bx = bx;
    prev_by = by;
    pos_x = wrap40(pos_x + rx);
    pos_y = wrap40(pos_y - ry);
    hd = (w > 5760 || w < -5760) ? w % 5760 : w;
    gx = wp_x[wp_sel] * 256 - pos_x;
    gy = wp_y[wp_sel] * 256 - pos_y;
    rad = radius * 256;
    r.reached = 0;
    if (gx < rad && -gx < rad && gy < rad && -gy < rad)
      if (gx * gx + gy * gy < rad * rad) r.reached = 1;
    if (r.reached) wp_sel = ~wp_sel;
    r.field_x = pos_x[39:0];
    r.field_y = pos_y[39:0];
    r.heading = hd[13:0];
    r.target_index = wp_sel;
    pending.push_back(r);
  endfunction

  // Compares one output transfer with the oldest prediction.
  function void check(logic [95:0] d);
    odo_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", d);
      return;
    end
    e = pending.pop_front();
    if (d[39:0] !== e.field_x || d[79:40] !== e.field_y || d[93:80] !== e.heading ||
        d[94] !== e.target_index || d[95] !== e.reached) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp x=%h y=%h hd=%h idx=%b hit=%b, got x=%h y=%h hd=%h idx=%b hit=%b",
                 e.field_x, e.field_y, e.heading, e.target_index, e.reached,
                 d[39:0], d[79:40], d[93:80], d[94], d[95]);
    end
  endfunction
endclass

module mecanum_odometry_waypoint_tracker_tb;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 120;
  localparam int RANDOM_PER_PHASE = 375;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  odometry_scoreboard sb;
  int  cycles;
  bit  quiet_tail;
  int  ready_hold;
  int  wheel[4];

  mecanum_odometry_waypoint_tracker i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  // Receiver backpressure in random bursts; none in the tail of the run.
  always @(negedge clk) begin
    if (quiet_tail) begin
      m_axis_tready = 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      m_axis_tready = ($urandom_range(0, 2) != 0);
      ready_hold = m_axis_tready ? $urandom_range(1, 40) : $urandom_range(1, 13);
    end
  end

  // Drives one wheel-angle transfer, starting at a falling edge.
  task automatic send_angles(input int lf, input int lr, input int rf, input int rr);
    s_axis_tdata = {rr, rf, lr, lf};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(s_axis_tdata);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    if (!quiet_tail && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Lets all pending results drain before touching the registers.
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_waypoints(input int x0, input int y0, input int x1, input int y1,
                               input int rad);
    wait_idle();
    write_cfg(mowt_pkg::REG_WP0_X, x0[15:0]);
    write_cfg(mowt_pkg::REG_WP0_Y, y0[15:0]);
    write_cfg(mowt_pkg::REG_WP1_X, x1[15:0]);
    write_cfg(mowt_pkg::REG_WP1_Y, y1[15:0]);
    write_cfg(mowt_pkg::REG_RADIUS, rad[15:0]);
    // An index beyond the register list must leave every setting alone.
    write_cfg(3'($urandom_range(5, 7)), 16'($urandom));
  endtask

  // Random walk of the wheels, mixed with zero steps and full-range noise.
  task automatic random_phase(input int count, input int step);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        for (int k = 0; k < 4; k++) wheel[k] = $urandom;
      end else if (pick < 13) begin
        // Same angles again: zero delta.
      end else begin
        for (int k = 0; k < 4; k++) wheel[k] += $urandom_range(0, 2 * step) - step;
      end
      send_angles(wheel[0], wheel[1], wheel[2], wheel[3]);
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    quiet_tail = 1'b0;
    ready_hold = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int k = 0; k < 4; k++) wheel[k] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero, extremes, repeated angles and headings around a full turn.
    send_angles(0, 0, 0, 0);
    send_angles(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_angles(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_angles(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_angles(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_angles(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_angles(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_angles(78821, 0, 0, 0);
    send_angles(78835, 0, 0, 0);
    send_angles(-78821, 0, 0, 0);
    send_angles(-78835, 0, 0, 0);
    send_angles(39410, 0, 0, 0);
    send_angles(-39410, 0, 0, 0);
    send_angles(19705, 0, 0, 0);
    send_angles(19720, 0, 0, 0);
    send_angles(-19720, 0, 0, 0);
    send_angles(1000, 2000, -3000, 500);
    send_angles(-1, -1, -1, -1);
    send_angles(1, 1, 1, 1);
    send_angles(0, 0, 0, 0);
    random_phase(RANDOM_PER_PHASE, 2000);

    // Waypoints at the origin with the widest radius: hits and index wrap.
    set_waypoints(0, 0, 0, 0, 65535);
    for (int k = 0; k < 4; k++) wheel[k] = 0;
    random_phase(RANDOM_PER_PHASE, 2000);

    // Extreme waypoints with a zero radius: never reached.
    set_waypoints(-32768, 32767, 32767, -32768, 0);
    random_phase(RANDOM_PER_PHASE, 20000);

    // Moderate waypoints and radius.
    set_waypoints($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                  $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300, 500);
    random_phase(RANDOM_PER_PHASE, 300);

    // Extreme waypoints with the widest radius, no idling on either side.
    set_waypoints(32767, -32768, -32768, 32767, 65535);
    quiet_tail = 1'b1;
    random_phase(RANDOM_PER_PHASE, 2000);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/mowt_pkg.sv
src/mowt_ctrl.sv
src/mowt_dp.sv
src/mecanum_odometry_waypoint_tracker.sv
sim/mecanum_odometry_waypoint_tracker_tb.sv
